// ===== rtl/core/jmsv_pkg.sv =====
// Shared constants and types for the JPEG marker stream validator.
package jmsv_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned DimW  = 16;

  localparam logic [ByteW-1:0] MK_FF   = 8'hFF;
  localparam logic [ByteW-1:0] MK_SOI  = 8'hD8;
  localparam logic [ByteW-1:0] MK_SOS  = 8'hDA;
  localparam logic [ByteW-1:0] MK_EOI  = 8'hD9;
  localparam logic [ByteW-1:0] MK_SOF0 = 8'hC0;
  localparam logic [ByteW-1:0] MK_RST0 = 8'hD0;
  localparam logic [ByteW-1:0] MK_STUF = 8'h00;

  typedef struct packed {
    logic            image_valid;
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
  } jmsv_res_t;

endpackage

// ===== rtl/core/jmsv_if.sv =====
// Byte input channel and result channel interfaces.
interface jmsv_in_if import jmsv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jmsv_out_if import jmsv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            image_valid;
  logic [DimW-1:0] image_width;
  logic [DimW-1:0] image_height;

  modport source (output valid, output image_valid, output image_width,
                  output image_height, input ready);
  modport sink (input valid, input image_valid, input image_width,
                input image_height, output ready);
endinterface

// ===== rtl/core/jpeg_marker_stream_validator.sv =====
// Top level of the JPEG marker stream validator.
// Takes a JPEG file one byte per transfer, last_byte set on the final byte, and
// returns one result per file on that final byte: image_valid plus the width and
// height from the last baseline frame header (0 if none). One byte per clock is
// sustained: a byte is registered on input, parsed from that register by a single
// level of marker-state logic, and a result lands in an output register,
// so input keeps flowing while a result waits; only the next final byte is held
// until that result is taken. Result valid rises from the output register once the
// final byte leaves the input register, unless an earlier result is still waiting.
// After the final byte the parser is back in its start state for the next file.
module jpeg_marker_stream_validator import jmsv_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  jmsv_in_if.sink    in_ch,
  jmsv_out_if.source out_ch
);

  logic             in_v_r;
  logic [ByteW-1:0] byte_r;
  logic             last_r;
  logic             out_v_r;
  jmsv_res_t        res_r;
  jmsv_res_t        res;
  logic             advance;

  assign advance     = in_v_r && (!last_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  jmsv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (byte_r),
    .last_byte (last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.data_byte;
      last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.image_valid  = res_r.image_valid;
  assign out_ch.image_width  = res_r.image_width;
  assign out_ch.image_height = res_r.image_height;

endmodule

// ===== rtl/core/jmsv_parser.sv =====
// Marker segment parser state and per-byte next-state logic.
module jmsv_parser import jmsv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  output jmsv_res_t        res
);

  localparam logic [3:0] PH_START0  = 4'd0;
  localparam logic [3:0] PH_START1  = 4'd1;
  localparam logic [3:0] PH_MARK_FF = 4'd2;
  localparam logic [3:0] PH_MARK    = 4'd3;
  localparam logic [3:0] PH_LEN_HI  = 4'd4;
  localparam logic [3:0] PH_LEN_LO  = 4'd5;
  localparam logic [3:0] PH_BODY    = 4'd6;
  localparam logic [3:0] PH_SCAN    = 4'd7;
  localparam logic [3:0] PH_SCAN_FF = 4'd8;

  logic [3:0]      phase_r, phase_nxt;
  logic [DimW-1:0] len_r, len_nxt;
  logic [DimW-1:0] off_r, off_nxt;
  logic            hdr_r, hdr_nxt;
  logic            seen_r, seen_nxt;
  logic [DimW-1:0] w_r, w_nxt;
  logic [DimW-1:0] h_r, h_nxt;
  logic            fail_r, fail_nxt;
  logic            eoi;
  logic            mark_en;
  logic [DimW-1:0] len_v;
  logic [DimW:0]   off_inc;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    off_nxt   = off_r;
    hdr_nxt   = hdr_r;
    seen_nxt  = seen_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    fail_nxt  = fail_r;
    eoi       = 1'b0;
    mark_en   = 1'b0;
    len_v     = len_r | {{(DimW-ByteW){1'b0}}, data_byte};
    off_inc   = {1'b0, off_r} + {{DimW{1'b0}}, 1'b1};
    if (!fail_r) begin
      unique case (phase_r)
        PH_START0: begin
          if (data_byte == MK_FF) phase_nxt = PH_START1;
          else fail_nxt = 1'b1;
        end
        PH_START1: begin
          if (data_byte == MK_SOI) phase_nxt = PH_MARK_FF;
          else fail_nxt = 1'b1;
        end
        PH_MARK_FF: begin
          if (data_byte == MK_FF) phase_nxt = PH_MARK;
          else fail_nxt = 1'b1;
        end
        PH_MARK: begin
          mark_en = 1'b1;
        end
        PH_LEN_HI: begin
          len_nxt   = {data_byte, {(DimW-ByteW){1'b0}}};
          off_nxt   = DimW'(1);
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt = len_v;
          if (len_v < DimW'(2) || (hdr_r && len_v < DimW'(7))) begin
            fail_nxt = 1'b1;
          end else if (len_v == DimW'(2)) begin
            phase_nxt = PH_MARK_FF;
          end else begin
            off_nxt   = DimW'(2);
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (hdr_r) begin
            unique case (off_r)
              DimW'(3): begin
                h_nxt = {data_byte, h_r[ByteW-1:0]};
              end
              DimW'(4): begin
                h_nxt = {h_r[DimW-1:ByteW], data_byte};
              end
              DimW'(5): begin
                w_nxt = {data_byte, w_r[ByteW-1:0]};
              end
              DimW'(6): begin
                w_nxt    = {w_r[DimW-1:ByteW], data_byte};
                seen_nxt = 1'b1;
              end
              default: begin
              end
            endcase
          end
          if (off_inc >= {1'b0, len_r}) begin
            phase_nxt = PH_MARK_FF;
            hdr_nxt   = 1'b0;
          end else begin
            off_nxt = off_inc[DimW-1:0];
          end
        end
        PH_SCAN: begin
          if (data_byte == MK_FF) phase_nxt = PH_SCAN_FF;
        end
        PH_SCAN_FF: begin
          if (data_byte == MK_STUF || data_byte[7:3] == MK_RST0[7:3]) phase_nxt = PH_SCAN;
          else mark_en = 1'b1;
        end
        default: begin
          fail_nxt = 1'b1;
        end
      endcase
      if (mark_en) begin
        priority if (data_byte == MK_SOS) begin
          phase_nxt = PH_SCAN;
        end else if (data_byte == MK_EOI) begin
          if (last_byte) eoi = 1'b1;
          else fail_nxt = 1'b1;
        end else begin
          hdr_nxt   = (data_byte == MK_SOF0);
          len_nxt   = '0;
          off_nxt   = '0;
          phase_nxt = PH_LEN_HI;
        end
      end
    end
  end

  assign res.image_valid  = eoi && !fail_nxt && seen_nxt;
  assign res.image_width  = w_nxt;
  assign res.image_height = h_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r <= PH_START0;
      len_r   <= '0;
      off_r   <= '0;
      hdr_r   <= 1'b0;
      seen_r  <= 1'b0;
      w_r     <= '0;
      h_r     <= '0;
      fail_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      off_r   <= off_nxt;
      hdr_r   <= hdr_nxt;
      seen_r  <= seen_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

// ===== bench/jmsv_stream_checker.sv =====
// Checker for the JPEG marker stream validator: watches both channels, predicts and compares.
module jmsv_stream_checker import jmsv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  jmsv_in_if   in_mon,
  jmsv_out_if  out_mon,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    SOI_FF, SOI_D8, MARK_FF, MARK_CODE, LEN_HI, LEN_LO, SEG_BODY, SCAN_DATA, SCAN_FF
  } parse_phase_t;

  parse_phase_t phase;
  logic [DimW-1:0] seg_len;
  logic [DimW-1:0] seg_off;
  logic [DimW-1:0] img_w;
  logic [DimW-1:0] img_h;
  logic in_sof;
  logic sof_seen;
  logic failed;

  jmsv_res_t expected_results[$];

  function automatic void clear_parser();
    phase    = SOI_FF;
    seg_len  = '0;
    seg_off  = '0;
    in_sof   = 1'b0;
    sof_seen = 1'b0;
    img_w    = '0;
    img_h    = '0;
    failed   = 1'b0;
  endfunction

  // returns 1 for an EOI that lands on the final byte
  function automatic logic enter_marker(input logic [ByteW-1:0] m, input logic last);
    if (m == MK_SOS) begin
      phase = SCAN_DATA;
      return 1'b0;
    end
    if (m == MK_EOI) begin
      if (last) return 1'b1;
      failed = 1'b1;
      return 1'b0;
    end
    in_sof  = (m == MK_SOF0);
    seg_len = '0;
    seg_off = '0;
    phase   = LEN_HI;
    return 1'b0;
  endfunction

  function automatic void advance_parser(input logic [ByteW-1:0] b, input logic last);
    logic      eoi;
    jmsv_res_t r;
    eoi = 1'b0;
    if (!failed) begin
      case (phase)
        SOI_FF: if (b == MK_FF) phase = SOI_D8; else failed = 1'b1;
        SOI_D8: if (b == MK_SOI) phase = MARK_FF; else failed = 1'b1;
        MARK_FF: if (b == MK_FF) phase = MARK_CODE; else failed = 1'b1;
        MARK_CODE: eoi = enter_marker(b, last);
        LEN_HI: begin
          seg_len = {b, 8'h00};
          seg_off = 16'd1;
          phase   = LEN_LO;
        end
        LEN_LO: begin
          seg_len = {seg_len[15:8], b};
          if (seg_len < 16'd2 || (in_sof && seg_len < 16'd7)) begin
            failed = 1'b1;
          end else if (seg_len == 16'd2) begin
            phase = MARK_FF;
          end else begin
            seg_off = 16'd2;
            phase   = SEG_BODY;
          end
        end
        SEG_BODY: begin
          if (in_sof) begin
            case (seg_off)
              16'd3: img_h[15:8] = b;
              16'd4: img_h[7:0]  = b;
              16'd5: img_w[15:8] = b;
              16'd6: begin
                img_w[7:0] = b;
                sof_seen   = 1'b1;
              end
              default: ;
            endcase
          end
          if ({1'b0, seg_off} + 17'd1 >= {1'b0, seg_len}) begin
            phase  = MARK_FF;
            in_sof = 1'b0;
          end else begin
            seg_off = seg_off + 16'd1;
          end
        end
        SCAN_DATA: if (b == MK_FF) phase = SCAN_FF;
        SCAN_FF: begin
          if (b == MK_STUF || b[7:3] == MK_RST0[7:3]) phase = SCAN_DATA;
          else eoi = enter_marker(b, last);
        end
        default: failed = 1'b1;
      endcase
    end
    if (last) begin
      r.image_valid  = eoi && !failed && sof_seen;
      r.image_width  = img_w;
      r.image_height = img_h;
      expected_results.push_back(r);
      clear_parser();
    end
  endfunction

  always @(posedge clk) begin
    jmsv_res_t got;
    jmsv_res_t want;
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.image_valid  = out_mon.image_valid;
        got.image_width  = out_mon.image_width;
        got.image_height = out_mon.image_height;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: valid=%b width=%h height=%h",
                     got.image_valid, got.image_width, got.image_height);
        end else begin
          want = expected_results.pop_front();
          if (got.image_valid !== want.image_valid ||
              got.image_width !== want.image_width ||
              got.image_height !== want.image_height) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected valid=%b width=%h height=%h,",
                        " got valid=%b width=%h height=%h"},
                       want.image_valid, want.image_width, want.image_height,
                       got.image_valid, got.image_width, got.image_height);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        advance_parser(in_mon.data_byte, in_mon.last_byte);
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== bench/jpeg_marker_stream_validator_test.sv =====
// Top of the JPEG marker stream validator testbench: clock, reset, byte stream and verdict.
module jpeg_marker_stream_validator_test import jmsv_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ByteW-1:0] MK_APP0 = 8'hE0;
  localparam logic [ByteW-1:0] MK_APP1 = 8'hE1;
  localparam logic [ByteW-1:0] MK_DQT  = 8'hDB;
  localparam logic [ByteW-1:0] MK_DHT  = 8'hC4;
  localparam logic [ByteW-1:0] MK_COM  = 8'hFE;
  localparam logic [ByteW-1:0] MK_DRI  = 8'hDD;
  localparam logic [ByteW-1:0] MK_SOF2 = 8'hC2;

  logic clk;
  logic rst_n = 1'b0;
  int   mismatches;
  int   outstanding;

  jmsv_in_if  in_ch ();
  jmsv_out_if out_ch ();

  jpeg_marker_stream_validator uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  jmsv_stream_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  logic [ByteW-1:0] jpeg_bytes[$];
  bit tx_steady;
  int results_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("jpeg_marker_stream_validator_test: errors");
    $finish;
  end

  function automatic logic [DimW-1:0] random_dim();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void put_frame_header(input bit sloppy);
    int len;
    logic [DimW-1:0] h;
    logic [DimW-1:0] w;
    logic [ByteW-1:0] b;
    len = (sloppy && $urandom_range(0, 1) == 1) ? $urandom_range(0, 6) : $urandom_range(7, 10);
    h = random_dim();
    w = random_dim();
    jpeg_bytes.push_back(MK_FF);
    jpeg_bytes.push_back(MK_SOF0);
    jpeg_bytes.push_back(len[15:8]);
    jpeg_bytes.push_back(len[7:0]);
    for (int off = 2; off < len; off++) begin
      case (off)
        3: b = h[15:8];
        4: b = h[7:0];
        5: b = w[15:8];
        6: b = w[7:0];
        default: b = 8'($urandom_range(0, 255));
      endcase
      jpeg_bytes.push_back(b);
    end
  endfunction

  function automatic void put_segment(input bit sloppy);
    logic [ByteW-1:0] m;
    int len;
    int body;
    case ($urandom_range(0, 8))
      0: m = MK_APP0;
      1: m = MK_APP1;
      2: m = MK_DQT;
      3: m = MK_DHT;
      4: m = MK_COM;
      5: m = MK_DRI;
      6: m = MK_SOF2;
      7: m = MK_FF;
      default: m = 8'($urandom_range(0, 255));
    endcase
    if (sloppy && $urandom_range(0, 1) == 1) len = $urandom_range(0, 3);
    else if (sloppy) len = $urandom_range(0, 65535);
    else len = $urandom_range(2, 6);
    body = (len > 8) ? 6 : ((len < 2) ? 0 : len - 2);
    jpeg_bytes.push_back(MK_FF);
    jpeg_bytes.push_back(m);
    jpeg_bytes.push_back(len[15:8]);
    jpeg_bytes.push_back(len[7:0]);
    repeat (body) jpeg_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_scan();
    jpeg_bytes.push_back(MK_FF);
    jpeg_bytes.push_back(MK_SOS);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0: begin
          jpeg_bytes.push_back(MK_FF);
          jpeg_bytes.push_back(MK_STUF);
        end
        1: begin
          jpeg_bytes.push_back(MK_FF);
          jpeg_bytes.push_back(MK_RST0 + 8'($urandom_range(0, 7)));
        end
        2: begin
          jpeg_bytes.push_back(MK_FF);
          jpeg_bytes.push_back(MK_SOS);
        end
        default: jpeg_bytes.push_back(8'($urandom_range(0, 254)));
      endcase
    end
  endfunction

  // kind 0: noise, 1: bad lengths and early EOI, 2: cut short, 3: one byte corrupted
  function automatic void build_file();
    int  kind;
    int  nseg;
    int  frame_at;
    bit  sloppy;
    bit  has_frame;
    int  cut;
    kind = $urandom_range(0, 9);
    jpeg_bytes.delete();
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) jpeg_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    sloppy    = (kind == 1);
    has_frame = ($urandom_range(0, 7) != 0);
    nseg      = $urandom_range(0, 2);
    frame_at  = $urandom_range(0, nseg);
    jpeg_bytes.push_back(MK_FF);
    jpeg_bytes.push_back(MK_SOI);
    for (int i = 0; i <= nseg; i++) begin
      if (i == frame_at && has_frame) put_frame_header(sloppy);
      else if (i != frame_at) put_segment(sloppy);
    end
    if (sloppy && $urandom_range(0, 1) == 1) begin
      jpeg_bytes.push_back(MK_FF);
      jpeg_bytes.push_back(MK_EOI);
    end
    if ($urandom_range(0, 3) != 0) begin
      put_scan();
      if ($urandom_range(0, 2) == 0) begin
        put_segment(1'b0);
        put_scan();
      end
    end
    jpeg_bytes.push_back(MK_FF);
    jpeg_bytes.push_back(MK_EOI);
    if (kind == 2) begin
      cut = $urandom_range(1, jpeg_bytes.size() - 1);
      while (jpeg_bytes.size() > cut) void'(jpeg_bytes.pop_back());
    end else if (kind == 3) begin
      jpeg_bytes[$urandom_range(0, jpeg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < jpeg_bytes.size(); i++)
      send_byte(jpeg_bytes[i], i == jpeg_bytes.size() - 1);
  endtask

  // result side: random stalls, calm streaks, and two long holds to back up the input
  initial begin
    int stall;
    int calm_left;
    out_ch.ready  = 1'b0;
    results_taken = 0;
    calm_left     = 0;
    wait (rst_n);
    forever begin
      if (results_taken == 4 || results_taken == 24) begin
        stall = 400;
      end else if (calm_left != 0) begin
        stall = 0;
        calm_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        stall     = 0;
        calm_left = $urandom_range(2, 6);
      end else begin
        stall = $urandom_range(0, 3);
      end
      if (stall != 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      results_taken++;
    end
  end

  initial begin
    int bytes_sent;
    int files_sent;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    tx_steady       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // baseline frame with extreme dimensions, stuffing and a restart inside the scan
    jpeg_bytes = '{MK_FF, MK_SOI, MK_FF, MK_SOF0, 8'h00, 8'h07, 8'h08,
                   8'hFF, 8'hFF, 8'h00, 8'h00, MK_FF, MK_SOS, 8'h12,
                   MK_FF, MK_STUF, MK_FF, MK_RST0 + 8'd3, MK_FF, MK_EOI};
    send_file();
    // wrong start byte on a one-byte file
    jpeg_bytes = '{MK_SOI};
    send_file();
    // EOI with no frame header
    jpeg_bytes = '{MK_FF, MK_SOI, MK_FF, MK_EOI};
    send_file();

    bytes_sent = 0;
    files_sent = 0;
    while (bytes_sent < 950 || files_sent < 40) begin
      build_file();
      tx_steady = ($urandom_range(0, 4) == 0);
      send_file();
      bytes_sent += jpeg_bytes.size();
      files_sent++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("jpeg_marker_stream_validator_test: clean");
    else
      $display("jpeg_marker_stream_validator_test: errors");
    $finish;
  end

endmodule
